// ===== hdl/scza_pkg.sv =====
`timescale 1ns / 1ps
// Package of the segment chase animator: sizes, codes, structs and constant tables.
// Depends on nothing; every other file of the block but scza_if.sv imports it.
package scza_pkg;

  // Display build constants.
  localparam int MUX_PHASES = 3;
  localparam int FULL_SCALE = 4095;
  localparam int PCT_FULL   = 100;

  // Field widths.
  localparam int SEG_N      = 8;
  localparam int RANK_W     = 3;
  localparam int LEVEL_W    = 12;
  localparam int PCT_W      = 7;
  localparam int PERIOD_W   = 16;
  localparam int CHAN_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Tick period divisor is 2 * MUX_PHASES * lit count; it is done as a
  // multiply by a rounded-up reciprocal followed by a right shift.
  localparam int DIV_MAX     = 2 * MUX_PHASES * SEG_N;
  localparam int DIV_LOG     = $clog2(DIV_MAX);
  localparam int RECIP_SHIFT = PERIOD_W + DIV_LOG;
  localparam int RECIP_W     = RECIP_SHIFT;
  localparam int PROD_W      = PERIOD_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_LUT [SEG_N] = '{
    RECIP_W'(((2 ** RECIP_SHIFT) + 2 * MUX_PHASES * 1 - 1) / (2 * MUX_PHASES * 1)),
    RECIP_W'(((2 ** RECIP_SHIFT) + 2 * MUX_PHASES * 2 - 1) / (2 * MUX_PHASES * 2)),
    RECIP_W'(((2 ** RECIP_SHIFT) + 2 * MUX_PHASES * 3 - 1) / (2 * MUX_PHASES * 3)),
    RECIP_W'(((2 ** RECIP_SHIFT) + 2 * MUX_PHASES * 4 - 1) / (2 * MUX_PHASES * 4)),
    RECIP_W'(((2 ** RECIP_SHIFT) + 2 * MUX_PHASES * 5 - 1) / (2 * MUX_PHASES * 5)),
    RECIP_W'(((2 ** RECIP_SHIFT) + 2 * MUX_PHASES * 6 - 1) / (2 * MUX_PHASES * 6)),
    RECIP_W'(((2 ** RECIP_SHIFT) + 2 * MUX_PHASES * 7 - 1) / (2 * MUX_PHASES * 7)),
    RECIP_W'(((2 ** RECIP_SHIFT) + 2 * MUX_PHASES * 8 - 1) / (2 * MUX_PHASES * 8))
  };

  // Percent to level table, one entry per 7-bit code; codes above 100 saturate.
  typedef logic [LEVEL_W-1:0] level_lut_t [2 ** PCT_W];

  function automatic level_lut_t build_level_lut();
    level_lut_t lut;
    int         p;
    for (int i = 0; i < 2 ** PCT_W; i++) begin
      p      = (i > PCT_FULL) ? PCT_FULL : i;
      lut[i] = LEVEL_W'((p * FULL_SCALE + PCT_FULL / 2) / PCT_FULL);
    end
    return lut;
  endfunction

  localparam level_lut_t LEVEL_LUT = build_level_lut();

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLYPH_BITS,
    CFG_MAX_PCT,
    CFG_MIN_PCT,
    CFG_BG_PCT,
    CFG_PERIOD_MS,
    CFG_WRAP_MODE,
    CFG_START_POS,
    CFG_START_DIR
  } cfg_idx_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_STEP,
    ST_LOAD
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic mul;
    logic step;
    logic load;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic glyph_empty;
  } dp_sts_t;

  // One result word.
  typedef struct packed {
    logic [SEG_N-1:0][LEVEL_W-1:0] level;
    logic [SEG_N-1:0]              write_mask;
    logic                          out_side;
    logic [CHAN_W-1:0]             out_base_channel;
    logic                          wrap_event;
  } res_t;

endpackage

// ===== hdl/scza_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the segment chase animator: tick words in,
// level words out. Depends on nothing.
interface scza_item_if;
  logic       valid;
  logic       ready;
  logic       side_select;
  logic [7:0] base_channel;

  modport source (output valid, output side_select, output base_channel, input ready);
  modport sink (input valid, input side_select, input base_channel, output ready);
endinterface

interface scza_res_if;
  logic        valid;
  logic        ready;
  logic [11:0] level_seg0;
  logic [11:0] level_seg1;
  logic [11:0] level_seg2;
  logic [11:0] level_seg3;
  logic [11:0] level_seg4;
  logic [11:0] level_seg5;
  logic [11:0] level_seg6;
  logic [11:0] level_seg7;
  logic [7:0]  write_mask;
  logic        out_side;
  logic [7:0]  out_base_channel;
  logic        wrap_event;

  modport source (
    output valid, output level_seg0, output level_seg1, output level_seg2,
    output level_seg3, output level_seg4, output level_seg5, output level_seg6,
    output level_seg7, output write_mask, output out_side, output out_base_channel,
    output wrap_event, input ready
  );
  modport sink (
    input valid, input level_seg0, input level_seg1, input level_seg2,
    input level_seg3, input level_seg4, input level_seg5, input level_seg6,
    input level_seg7, input write_mask, input out_side, input out_base_channel,
    input wrap_event, output ready
  );
endinterface

// ===== hdl/scza_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the segment chase animator: steps each tick word through the
// datapath and owns the output word valid flag. Depends on scza_pkg.
module scza_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  scza_pkg::dp_sts_t  sts_i,
  output scza_pkg::ctl_cmd_t cmd_o
);
  import scza_pkg::*;

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The output register can take a new word when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !sts_i.glyph_empty) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_STEP;
      ST_STEP: state_d = ST_LOAD;
      ST_LOAD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: handshake and datapath commands.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i && !sts_i.glyph_empty;
      end
      ST_MUL:  cmd_o.mul  = 1'b1;
      ST_STEP: cmd_o.step = 1'b1;
      ST_LOAD: cmd_o.load = out_free;
      default: ;
    endcase
  end

  // Output word valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/scza_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the segment chase animator: configuration registers, tick counter,
// chase position, period multiply, level mapping and output register. Uses scza_pkg.
module scza_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [scza_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [scza_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             side_select_i,
  input  logic [scza_pkg::CHAN_W-1:0]      base_channel_i,
  input  scza_pkg::ctl_cmd_t               cmd_i,
  output scza_pkg::dp_sts_t                sts_o,
  output scza_pkg::res_t                   res_o
);
  import scza_pkg::*;

  // Configuration registers.
  logic [SEG_N-1:0]    glyph_q;
  logic [PCT_W-1:0]    max_pct_q, min_pct_q, bg_pct_q;
  logic [PERIOD_W-1:0] period_ms_q;
  logic                wrap_mode_q;

  // Animation state.
  logic [PERIOD_W-1:0] tick_q, tick_d;
  logic signed [4:0]   pos_q, pos_d;
  logic signed [1:0]   dir_q, dir_d;
  logic                wrap_q, wrap_d;

  // Captured tick word and intermediate product.
  logic                side_q;
  logic [CHAN_W-1:0]   base_q;
  logic [PROD_W-1:0]   product_q;
  res_t                res_q, res_d;

  logic [RANK_W:0]     size;
  logic [RANK_W-1:0]   last;
  logic [PERIOD_W-1:0] period;
  logic signed [4:0]   moved;
  logic signed [4:0]   last_s;
  logic [RANK_W:0]     cnt;
  logic [RANK_W-1:0]   rank [SEG_N];
  logic [RANK_W-1:0]   pos3;
  logic [RANK_W-1:0]   trail;
  logic                trail_ok;
  logic [LEVEL_W-1:0]  max_lvl, min_lvl, bg_lvl;

  // Lit segment count and the rank of each segment among the lit ones.
  always_comb begin
    cnt = '0;
    for (int i = 0; i < SEG_N; i++) begin
      rank[i] = cnt[RANK_W-1:0];
      cnt     = cnt + (RANK_W + 1)'(glyph_q[i]);
    end
    size = cnt;
  end

  assign last              = RANK_W'(size - (RANK_W + 1)'(1));
  assign sts_o.glyph_empty = (glyph_q == '0);

  // Tick period is the upper part of the reciprocal product.
  assign period = product_q[RECIP_SHIFT +: PERIOD_W];

  // Counter advance, position step and end handling.
  always_comb begin
    tick_d = tick_q + PERIOD_W'(1);
    moved  = pos_q;
    if (tick_q == period) begin
      tick_d = '0;
      moved  = pos_q + 5'($signed(dir_q));
    end
    last_s = $signed({2'b00, last});
    pos_d  = moved;
    dir_d  = dir_q;
    wrap_d = 1'b0;
    if (moved < 5'sd0) begin
      if (wrap_mode_q) begin
        pos_d  = last_s;
        wrap_d = 1'b1;
      end else begin
        pos_d = '0;
        dir_d = 2'sd1;
      end
    end else if (moved > last_s) begin
      if (wrap_mode_q) begin
        pos_d  = '0;
        wrap_d = 1'b1;
      end else begin
        pos_d = (last != '0) ? (last_s - 5'sd1) : 5'sd0;
        dir_d = -2'sd1;
      end
    end
  end

  // Trailing neighbour: the rank just behind the current one in the step direction.
  assign pos3 = pos_q[RANK_W-1:0];
  always_comb begin
    trail    = pos3;
    trail_ok = 1'b0;
    if (dir_q == 2'sd1 && pos3 != '0) begin
      trail    = pos3 - RANK_W'(1);
      trail_ok = 1'b1;
    end else if (dir_q == -2'sd1 && pos3 < last) begin
      trail    = pos3 + RANK_W'(1);
      trail_ok = 1'b1;
    end
  end

  assign max_lvl = LEVEL_LUT[max_pct_q];
  assign min_lvl = LEVEL_LUT[min_pct_q];
  assign bg_lvl  = LEVEL_LUT[bg_pct_q];

  // Level per segment and the rest of the result word.
  always_comb begin
    for (int i = 0; i < SEG_N; i++) begin
      if (!glyph_q[i]) begin
        res_d.level[i] = '0;
      end else if (rank[i] == pos3) begin
        res_d.level[i] = max_lvl;
      end else if (trail_ok && rank[i] == trail) begin
        res_d.level[i] = min_lvl;
      end else begin
        res_d.level[i] = bg_lvl;
      end
    end
    res_d.write_mask       = glyph_q;
    res_d.out_side         = side_q;
    res_d.out_base_channel = base_q;
    res_d.wrap_event       = wrap_q;
  end

  // Configuration and animation state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_q     <= '0;
      max_pct_q   <= PCT_W'(PCT_FULL);
      min_pct_q   <= '0;
      bg_pct_q    <= '0;
      period_ms_q <= '0;
      wrap_mode_q <= 1'b0;
      tick_q      <= '0;
      pos_q       <= '0;
      dir_q       <= 2'sd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GLYPH_BITS: glyph_q     <= cfg_data_i[SEG_N-1:0];
        CFG_MAX_PCT:    max_pct_q   <= cfg_data_i[PCT_W-1:0];
        CFG_MIN_PCT:    min_pct_q   <= cfg_data_i[PCT_W-1:0];
        CFG_BG_PCT:     bg_pct_q    <= cfg_data_i[PCT_W-1:0];
        CFG_PERIOD_MS:  period_ms_q <= cfg_data_i[PERIOD_W-1:0];
        CFG_WRAP_MODE:  wrap_mode_q <= cfg_data_i[0];
        CFG_START_POS: begin
          pos_q  <= $signed({2'b00, cfg_data_i[RANK_W-1:0]});
          tick_q <= '0;
        end
        CFG_START_DIR: begin
          dir_q <= $signed(cfg_data_i[1:0]);
        end
        default: ;
      endcase
    end else if (cmd_i.step) begin
      tick_q <= tick_d;
      pos_q  <= pos_d;
      dir_q  <= dir_d;
    end
  end

  // Payload registers: captured tick word, product, wrap flag, result word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      side_q <= side_select_i;
      base_q <= base_channel_i;
    end
    if (cmd_i.mul) begin
      product_q <= PROD_W'(period_ms_q) * PROD_W'(RECIP_LUT[last]);
    end
    if (cmd_i.step) begin
      wrap_q <= wrap_d;
    end
    if (cmd_i.load) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== hdl/segment_chase_zigzag_animator_top.sv =====
`timescale 1ns / 1ps
// Segment chase animator top level. An accepted tick word goes through the multiply,
// step and load states before its level word is valid; the load waits while an older
// word is pending. One tick word at a time: no new one is taken until the word is loaded.
// Ticks with an empty glyph give no word. Reset is asynchronous, active low; it loads the
// control, config and animation registers with their defaults and leaves no word pending.
module segment_chase_zigzag_animator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [scza_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [scza_pkg::CFG_DATA_W-1:0] cfg_data_i,
  scza_item_if.sink                       item_i,
  scza_res_if.source                      result_o
);
  import scza_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;
  res_t     res;
  logic     out_valid;

  // Sequencer.
  scza_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath.
  scza_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .side_select_i  (item_i.side_select),
    .base_channel_i (item_i.base_channel),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .res_o          (res)
  );

  // Result word onto the output channel.
  assign result_o.valid            = out_valid;
  assign result_o.level_seg0       = res.level[0];
  assign result_o.level_seg1       = res.level[1];
  assign result_o.level_seg2       = res.level[2];
  assign result_o.level_seg3       = res.level[3];
  assign result_o.level_seg4       = res.level[4];
  assign result_o.level_seg5       = res.level[5];
  assign result_o.level_seg6       = res.level[6];
  assign result_o.level_seg7       = res.level[7];
  assign result_o.write_mask       = res.write_mask;
  assign result_o.out_side         = res.out_side;
  assign result_o.out_base_channel = res.out_base_channel;
  assign result_o.wrap_event       = res.wrap_event;

  // At most one datapath command at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.capture, cmd.mul, cmd.step, cmd.load}))
    else $error("more than one datapath command active");

  // The state update always follows the period multiply.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> $past(cmd.mul))
    else $error("step issued without a preceding multiply");

  // A new word appears only from a load, and never for an empty glyph.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(cmd.load) && res.write_mask != '0)
    else $error("result word without load or with empty glyph");

  // A pending word is not overwritten before it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !out_valid || result_o.ready)
    else $error("result word overwritten while pending");

endmodule

// ===== tb/scza_chase_checker.sv =====
`timescale 1ns / 1ps
// Checker for the segment chase animator: follows the config port and the tick channel,
// predicts each level word, and compares it with the words the block delivers.
// Depends on scza_pkg and the channel interfaces in scza_if.sv.
module scza_chase_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [scza_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [scza_pkg::CFG_DATA_W-1:0] cfg_data_i,
  scza_item_if                            item_mon,
  scza_res_if                             res_mon,
  output int                              fail_count_o,
  output int                              pending_o
);
  import scza_pkg::*;

  // Shadow copy of the configuration registers.
  logic [SEG_N-1:0]    glyph_r;
  logic [PCT_W-1:0]    max_pct_r;
  logic [PCT_W-1:0]    min_pct_r;
  logic [PCT_W-1:0]    bg_pct_r;
  logic [PERIOD_W-1:0] period_ms_r;
  logic                wrap_r;

  // Shadow copy of the chase state.
  logic [PERIOD_W-1:0] tick_cnt;
  int                  chase_pos;
  int                  step_dir;

  res_t level_words_q[$];

  // Percent to level, rounding halves up; codes above full percent saturate.
  function automatic logic [LEVEL_W-1:0] pct_level(logic [PCT_W-1:0] pct);
    int p;
    p = (int'(pct) > PCT_FULL) ? PCT_FULL : int'(pct);
    return LEVEL_W'((p * FULL_SCALE + PCT_FULL / 2) / PCT_FULL);
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    fail_count_o++;
    $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
  endtask

  task automatic apply_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    case (cfg_idx_e'(idx))
      CFG_GLYPH_BITS: glyph_r = data[SEG_N-1:0];
      CFG_MAX_PCT:    max_pct_r = data[PCT_W-1:0];
      CFG_MIN_PCT:    min_pct_r = data[PCT_W-1:0];
      CFG_BG_PCT:     bg_pct_r = data[PCT_W-1:0];
      CFG_PERIOD_MS:  period_ms_r = data[PERIOD_W-1:0];
      CFG_WRAP_MODE:  wrap_r = data[0];
      CFG_START_POS: begin
        // Loading a start rank also restarts the tick counter.
        chase_pos = int'(data[RANK_W-1:0]);
        tick_cnt = '0;
      end
      CFG_START_DIR:  step_dir = int'($signed(data[1:0]));
      default: ;
    endcase
  endtask

  // Advance the chase by one tick and queue the level word it produces.
  task automatic predict_tick(input logic side, input logic [CHAN_W-1:0] chan);
    int   rank_bit [SEG_N];
    int   lit_n;
    int   top_rank;
    int   tick_period;
    logic wrapped;
    res_t want;
    lit_n = 0;
    wrapped = 1'b0;
    for (int b = 0; b < SEG_N; b++) begin
      if (glyph_r[b]) begin
        rank_bit[lit_n] = b;
        lit_n++;
      end
    end
    // An empty glyph gives no word and leaves the state alone.
    if (lit_n == 0) return;
    top_rank = lit_n - 1;
    tick_period = int'(period_ms_r) / (2 * MUX_PHASES * lit_n);

    if (tick_cnt == PERIOD_W'(tick_period)) begin
      chase_pos += step_dir;
      tick_cnt = '0;
    end else begin
      tick_cnt = tick_cnt + PERIOD_W'(1);
    end

    // Out-of-range positions are folded back on every tick.
    if (chase_pos < 0) begin
      if (wrap_r) begin
        chase_pos = top_rank;
        wrapped = 1'b1;
      end else begin
        chase_pos = 0;
        step_dir = 1;
      end
    end else if (chase_pos > top_rank) begin
      if (wrap_r) begin
        chase_pos = 0;
        wrapped = 1'b1;
      end else begin
        chase_pos = (top_rank > 0) ? top_rank - 1 : 0;
        step_dir = -1;
      end
    end

    want = '0;
    for (int r = 0; r < lit_n; r++)
      want.level[rank_bit[r]] = pct_level(bg_pct_r);
    want.level[rank_bit[chase_pos]] = pct_level(max_pct_r);
    // Only a unit step marks the segment just behind the light.
    if (step_dir == 1 && chase_pos > 0)
      want.level[rank_bit[chase_pos - 1]] = pct_level(min_pct_r);
    if (step_dir == -1 && chase_pos < top_rank)
      want.level[rank_bit[chase_pos + 1]] = pct_level(min_pct_r);
    want.write_mask = glyph_r;
    want.out_side = side;
    want.out_base_channel = chan;
    want.wrap_event = wrapped;
    level_words_q.push_back(want);
    pending_o = level_words_q.size();
  endtask

  // Compare one delivered word with the oldest prediction, field by field.
  task automatic check_word();
    res_t got;
    res_t want;
    got.level[0] = res_mon.level_seg0;
    got.level[1] = res_mon.level_seg1;
    got.level[2] = res_mon.level_seg2;
    got.level[3] = res_mon.level_seg3;
    got.level[4] = res_mon.level_seg4;
    got.level[5] = res_mon.level_seg5;
    got.level[6] = res_mon.level_seg6;
    got.level[7] = res_mon.level_seg7;
    got.write_mask = res_mon.write_mask;
    got.out_side = res_mon.out_side;
    got.out_base_channel = res_mon.out_base_channel;
    got.wrap_event = res_mon.wrap_event;
    if (level_words_q.size() == 0) begin
      fail_count_o++;
      $display("%0t ns: unexpected level word, expected none, got %h", $time, got);
      return;
    end
    want = level_words_q.pop_front();
    pending_o = level_words_q.size();
    for (int s = 0; s < SEG_N; s++) begin
      if (got.level[s] !== want.level[s])
        note_mismatch($sformatf("level_seg%0d", s), int'(want.level[s]),
                      int'(got.level[s]));
    end
    if (got.write_mask !== want.write_mask)
      note_mismatch("write_mask", int'(want.write_mask), int'(got.write_mask));
    if (got.out_side !== want.out_side)
      note_mismatch("out_side", int'(want.out_side), int'(got.out_side));
    if (got.out_base_channel !== want.out_base_channel)
      note_mismatch("out_base_channel", int'(want.out_base_channel),
                    int'(got.out_base_channel));
    if (got.wrap_event !== want.wrap_event)
      note_mismatch("wrap_event", int'(want.wrap_event), int'(got.wrap_event));
  endtask

  // Watch all ports on every rising edge; reset restores the register defaults.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_r = '0;
      max_pct_r = PCT_W'(PCT_FULL);
      min_pct_r = '0;
      bg_pct_r = '0;
      period_ms_r = '0;
      wrap_r = 1'b0;
      tick_cnt = '0;
      chase_pos = 0;
      step_dir = 1;
      level_words_q.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i)
        apply_config(cfg_idx_i, cfg_data_i);
      if (item_mon.valid && item_mon.ready)
        predict_tick(item_mon.side_select, item_mon.base_channel);
      if (res_mon.valid && res_mon.ready)
        check_word();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the segment chase animator testbench: clock, reset, config writes, tick words
// and result back-pressure; the verdict comes from the checker's failure count.
// Depends on scza_pkg, scza_if.sv, the block's top level and scza_chase_checker.
module testbench;
  import scza_pkg::*;

  // Step direction codes as written to the start direction register.
  localparam logic [1:0] DIR_UP          = 2'b01;
  localparam logic [1:0] DIR_DOWN        = 2'b11;
  localparam logic [1:0] DIR_HOLD        = 2'b00;
  localparam logic [1:0] DIR_DOUBLE_DOWN = 2'b10;

  localparam int RANDOM_TICKS = 1400;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    fail_count;
  int                    pending_words;
  logic [SEG_N-1:0]      cur_glyph;
  logic                  stall_en;

  scza_item_if tick_ch ();
  scza_res_if  level_ch ();

  segment_chase_zigzag_animator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (tick_ch),
    .result_o   (level_ch)
  );

  scza_chase_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_mon     (tick_ch),
    .res_mon      (level_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PCT_W-1:0] pick_pct();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return PCT_W'(PCT_FULL);
    if (r < 40) return '1;
    if (r < 50) return PCT_W'($urandom_range(PCT_FULL + 1, 127));
    return PCT_W'($urandom_range(0, PCT_FULL));
  endfunction

  // Small periods keep the light moving; large ones show up now and then.
  function automatic logic [PERIOD_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 20) return PERIOD_W'($urandom_range(1, 12));
    if (r < 60) return PERIOD_W'($urandom_range(13, 60));
    if (r < 85) return PERIOD_W'($urandom_range(61, 400));
    if (r < 95) return PERIOD_W'($urandom);
    return '1;
  endfunction

  function automatic logic [SEG_N-1:0] pick_glyph();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 25) return SEG_N'(1) << $urandom_range(0, SEG_N - 1);
    if (r < 35) return '1;
    return SEG_N'($urandom);
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_GLYPH_BITS)
      cur_glyph = data[SEG_N-1:0];
  endtask

  task automatic set_config(input logic [SEG_N-1:0] glyph, input logic [PCT_W-1:0] max_pct,
                            input logic [PCT_W-1:0] min_pct, input logic [PCT_W-1:0] bg_pct,
                            input logic [PERIOD_W-1:0] period_ms, input logic wrap,
                            input logic [RANK_W-1:0] start_rank, input logic [1:0] start_dir);
    write_reg(CFG_GLYPH_BITS, CFG_DATA_W'(glyph));
    write_reg(CFG_MAX_PCT, CFG_DATA_W'(max_pct));
    write_reg(CFG_MIN_PCT, CFG_DATA_W'(min_pct));
    write_reg(CFG_BG_PCT, CFG_DATA_W'(bg_pct));
    write_reg(CFG_PERIOD_MS, CFG_DATA_W'(period_ms));
    write_reg(CFG_WRAP_MODE, CFG_DATA_W'(wrap));
    write_reg(CFG_START_POS, CFG_DATA_W'(start_rank));
    write_reg(CFG_START_DIR, CFG_DATA_W'(start_dir));
  endtask

  // Offer one tick word after an optional gap and hold it until accepted.
  // Valid stays high across back-to-back words.
  task automatic send_tick(input logic side, input logic [CHAN_W-1:0] chan, input int gap);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.side_select <= side;
    tick_ch.base_channel <= chan;
    @(posedge clk_i);
    while (!tick_ch.ready) @(posedge clk_i);
  endtask

  // Tick word with random side and channel.
  task automatic send_random_tick(input int gap);
    send_tick(1'($urandom), CHAN_W'($urandom), gap);
  endtask

  // Let every predicted word arrive, then give an empty-glyph tick time to finish.
  task automatic settle();
    tick_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Rewrite a random subset of the registers; the rest keep their values.
  task automatic shuffle_config();
    if ($urandom_range(0, 9) < 7) write_reg(CFG_GLYPH_BITS, CFG_DATA_W'(pick_glyph()));
    if ($urandom_range(0, 9) < 5) write_reg(CFG_MAX_PCT, CFG_DATA_W'(pick_pct()));
    if ($urandom_range(0, 9) < 5) write_reg(CFG_MIN_PCT, CFG_DATA_W'(pick_pct()));
    if ($urandom_range(0, 9) < 5) write_reg(CFG_BG_PCT, CFG_DATA_W'(pick_pct()));
    if ($urandom_range(0, 9) < 6) write_reg(CFG_PERIOD_MS, CFG_DATA_W'(pick_period()));
    if ($urandom_range(0, 9) < 5) write_reg(CFG_WRAP_MODE, CFG_DATA_W'($urandom_range(0, 1)));
    if ($urandom_range(0, 9) < 5) write_reg(CFG_START_POS, CFG_DATA_W'($urandom_range(0, 7)));
    if ($urandom_range(0, 9) < 5) write_reg(CFG_START_DIR, CFG_DATA_W'($urandom_range(0, 3)));
  endtask

  // Result back-pressure: runs of ready high broken by stalls of random length.
  initial begin
    level_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      level_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      if (stall_en) begin
        level_ch.ready <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3))
          @(posedge clk_i);
      end
    end
  end

  initial begin
    int   counted;
    int   n;
    logic calm;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    tick_ch.valid <= 1'b0;
    tick_ch.side_select <= 1'b0;
    tick_ch.base_channel <= '0;
    cur_glyph = '0;
    stall_en = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset glyph is empty: these ticks must produce no word.
    send_tick(1'b0, 8'h00, 0);
    send_tick(1'b1, 8'hFF, 1);
    settle();

    // Full glyph starting on the last rank: wrap at the top, saturated max percent.
    set_config(8'hFF, 7'd127, 7'd0, 7'd100, 16'd0, 1'b1, 3'd7, DIR_UP);
    send_tick(1'b1, 8'hFF, 0);
    send_tick(1'b0, 8'h00, 0);
    send_tick(1'b1, 8'h5A, 2);
    send_tick(1'b0, 8'hA5, 0);
    settle();

    // Three lit segments, start rank past the end, bounce off both ends going down.
    set_config(8'hA4, 7'd100, 7'd127, 7'd0, 16'd0, 1'b0, 3'd5, DIR_DOWN);
    repeat (4) send_random_tick(0);
    settle();

    // Single lit segment bouncing off the top stays on rank zero.
    set_config(8'h80, 7'd50, 7'd25, 7'd75, 16'd0, 1'b0, 3'd0, DIR_UP);
    repeat (2) send_random_tick(1);
    settle();

    // Zero direction never moves; a double step down wraps past the bottom.
    set_config(8'h0F, 7'd100, 7'd10, 7'd33, 16'd0, 1'b0, 3'd2, DIR_HOLD);
    repeat (2) send_random_tick(0);
    settle();
    write_reg(CFG_WRAP_MODE, 16'd1);
    write_reg(CFG_START_DIR, CFG_DATA_W'(DIR_DOUBLE_DOWN));
    repeat (3) send_random_tick(0);
    settle();

    // Shorten the period after the counter has passed it: the counter keeps going.
    set_config(8'h11, 7'd100, 7'd0, 7'd20, 16'd60, 1'b0, 3'd0, DIR_UP);
    repeat (5) send_random_tick(0);
    settle();
    write_reg(CFG_PERIOD_MS, 16'd12);
    repeat (3) send_random_tick(0);
    settle();

    // Counter past a zero period keeps counting, at full rate.
    set_config(8'h03, 7'd100, 7'd0, 7'd50, 16'hFFFF, 1'b0, 3'd0, DIR_UP);
    repeat (3) send_random_tick(0);
    settle();
    write_reg(CFG_PERIOD_MS, 16'd0);
    stall_en = 1'b0;
    repeat (20) send_random_tick(0);
    settle();

    // Random phases; ticks on an empty glyph are not counted.
    counted = 0;
    while (counted < RANDOM_TICKS) begin
      settle();
      shuffle_config();
      calm = ($urandom_range(0, 3) == 0);
      stall_en = !calm;
      n = $urandom_range(10, 60);
      repeat (n) begin
        send_random_tick(calm ? 0 : pick_gap());
        if (cur_glyph != '0) counted++;
      end
    end
    settle();
    repeat (20) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
